@@ sv/sft_pkg.sv @@
// Shared types, constants and codes for the sample frame transposer.
package sft_pkg;

  localparam int MAX_COLS    = 64;
  localparam int MAX_ROWS    = 64;
  localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);
  localparam int DIM_W       = 7;
  localparam int COL_W       = $clog2(MAX_COLS);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int WORD_W      = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 7;

  // Depth of the op queue and of the result queue.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_COLS         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NARROW_INPUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESCALE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_BYTES   = 3'd4;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_FETCH = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_EARLY_FETCH = 2'd1,
    ST_DROPPED     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_ERROR = 2'd2
  } op_kind_t;

  typedef struct packed {
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] rows;
    logic             narrow_input;
    logic             rescale;
    logic             swap_bytes;
  } cfg_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
    logic              last;
    status_t           status;
  } op_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              last;
    status_t           status;
  } res_t;

endpackage

@@ sv/sample_frame_transposer_unit.sv @@
// Top level of the sample frame transposer: config registers, front end, op queue, back end.
//
// Load transactions (command 0) fill a row-major frame of cols x rows samples into a
// 4096-word store, converted on the way in (optional 8-bit low byte, optional *257 stretch,
// optional byte swap). Once the frame is complete, fetch transactions (command 1) return
// it column by column, each column top to bottom; the final word carries last and frees
// the store for the next frame. A load into a complete frame gives a result with status 2,
// a fetch before the frame is complete gives status 1, both with value 0. Other loads give
// no result. The block takes one transaction per cycle, sustained, as long as results are
// popped: the front end decides each transaction in the cycle it is pushed, and the back
// end retires one op per cycle against the single-port-per-side frame RAM. A result
// reaches the output ports through the op queue register, the RAM's registered read and
// the result queue register. full rises when the four-entry op queue fills, which happens
// only while the four-entry result queue is backed up. Out-of-range cols and rows are
// saturated to 1..64. Configuration must be written through cfg_write / cfg_index /
// cfg_data only while the block is idle; the block itself does not enforce this. The
// store needs no clearing after reset.
module sample_frame_transposer_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [sft_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sft_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           push,
  output logic                           full,
  input  logic                           command,
  input  logic [sft_pkg::WORD_W-1:0]     sample,
  output logic                           empty,
  input  logic                           pop,
  output logic [sft_pkg::WORD_W-1:0]     value,
  output logic                           last,
  output logic [1:0]                     status
);
  import sft_pkg::*;

  cfg_t cfg;
  logic accept;
  logic op_push, q_valid, q_pop;
  op_t  op_in, q_head;
  res_t res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cols         <= DIM_W'(MAX_COLS);
      cfg.rows         <= DIM_W'(MAX_ROWS);
      cfg.narrow_input <= 1'b1;
      cfg.rescale      <= 1'b0;
      cfg.swap_bytes   <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COLS:         cfg.cols         <= cfg_data;
        REG_ROWS:         cfg.rows         <= cfg_data;
        REG_NARROW_INPUT: cfg.narrow_input <= cfg_data[0];
        REG_RESCALE:      cfg.rescale      <= cfg_data[0];
        REG_SWAP_BYTES:   cfg.swap_bytes   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  // Front end: classification and frame counters
  sft_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .command (command),
    .sample  (sample),
    .op_push (op_push),
    .op      (op_in)
  );

  // Op queue decouples the two halves
  sft_op_queue u_op_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (op_push),
    .push_op (op_in),
    .full    (full),
    .pop     (q_pop),
    .valid   (q_valid),
    .head    (q_head)
  );

  // Back end: frame RAM and result queue
  sft_back u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (q_valid),
    .op        (q_head),
    .op_pop    (q_pop),
    .res_pop   (pop),
    .res_empty (empty),
    .res       (res)
  );

  assign value  = res.value;
  assign last   = res.last;
  assign status = res.status;

endmodule

@@ sv/sft_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sft_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/sft_front.sv @@
// Front end: classifies each transaction, keeps the frame counters, builds store ops.
module sft_front (
  input  logic                       clk,
  input  logic                       rst,
  input  sft_pkg::cfg_t              cfg,
  input  logic                       accept,
  input  logic                       command,
  input  logic [sft_pkg::WORD_W-1:0] sample,
  output logic                       op_push,
  output sft_pkg::op_t               op
);
  import sft_pkg::*;

  logic [COUNT_W-1:0] load_count, load_count_next;
  logic [COL_W-1:0]   out_col, out_col_next;
  logic [ROW_W-1:0]   out_row, out_row_next;
  logic               frame_full, frame_full_next;

  logic [DIM_W-1:0]   ec, er;
  logic [COUNT_W-1:0] size;
  logic [COUNT_W-1:0] count_inc;
  logic [COUNT_W-1:0] rd_addr;
  logic [ROW_W:0]     row_inc;
  logic [COL_W:0]     col_inc;
  logic               room;
  logic [WORD_W-1:0]  conv;
  logic [7:0]         lo_byte;

  // Sizes saturated to 1..MAX.
  always_comb begin
    ec = cfg.cols;
    if (cfg.cols == '0) ec = DIM_W'(1);
    else if (cfg.cols > DIM_W'(MAX_COLS)) ec = DIM_W'(MAX_COLS);
    er = cfg.rows;
    if (cfg.rows == '0) er = DIM_W'(1);
    else if (cfg.rows > DIM_W'(MAX_ROWS)) er = DIM_W'(MAX_ROWS);
  end

  assign size    = COUNT_W'(ec) * COUNT_W'(er);
  assign rd_addr = COUNT_W'(out_row) * COUNT_W'(ec) + COUNT_W'(out_col);
  assign room    = load_count < COUNT_W'(STORE_DEPTH);
  assign count_inc = room ? load_count + COUNT_W'(1) : load_count;
  assign row_inc = {1'b0, out_row} + (ROW_W+1)'(1);
  assign col_inc = {1'b0, out_col} + (COL_W+1)'(1);

  // Sample conversion, applied as the sample is stored.
  always_comb begin
    lo_byte = sample[7:0];
    conv    = sample;
    if (cfg.narrow_input) begin
      conv = cfg.rescale ? {lo_byte, lo_byte} : {8'h00, lo_byte};
    end
    if (cfg.swap_bytes) conv = {conv[7:0], conv[15:8]};
  end

  always_comb begin
    load_count_next = load_count;
    out_col_next    = out_col;
    out_row_next    = out_row;
    frame_full_next = frame_full;
    op_push         = 1'b0;
    op.kind         = OP_ERROR;
    op.addr         = load_count[ADDR_W-1:0];
    op.data         = conv;
    op.last         = 1'b0;
    op.status       = ST_OK;
    if (accept) begin
      op_push = 1'b1;
      if (command == CMD_LOAD) begin
        if (frame_full) begin
          op.status = ST_DROPPED;
        end else begin
          op.kind = OP_WRITE;
          op_push = room;
          load_count_next = count_inc;
          if (count_inc >= size) frame_full_next = 1'b1;
        end
      end else begin
        if (!frame_full) begin
          op.status = ST_EARLY_FETCH;
        end else begin
          op.kind = OP_READ;
          op.addr = rd_addr[ADDR_W-1:0];
          out_row_next = row_inc[ROW_W-1:0];
          if (row_inc >= (ROW_W+1)'(er)) begin
            out_row_next = '0;
            out_col_next = col_inc[COL_W-1:0];
            if (col_inc >= (COL_W+1)'(ec)) begin
              op.last         = 1'b1;
              load_count_next = '0;
              out_col_next    = '0;
              frame_full_next = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      out_col    <= '0;
      out_row    <= '0;
      frame_full <= 1'b0;
    end else begin
      load_count <= load_count_next;
      out_col    <= out_col_next;
      out_row    <= out_row_next;
      frame_full <= frame_full_next;
    end
  end

endmodule

@@ sv/sft_op_queue.sv @@
// Short queue of store ops between the front end and the back end.
module sft_op_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  sft_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output sft_pkg::op_t head
);
  import sft_pkg::*;

  op_t               mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign full   = count == QCNT_W'(QUEUE_DEPTH);
  assign valid  = count != '0;
  assign head   = mem[rd_ptr];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)   wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + QCNT_W'(push) - QCNT_W'(do_pop);
    end
  end

endmodule

@@ sv/sft_back.sv @@
// Back end: carries out store ops on the frame RAM and queues the results.
module sft_back (
  input  logic         clk,
  input  logic         rst,
  input  logic         op_valid,
  input  sft_pkg::op_t op,
  output logic         op_pop,
  input  logic         res_pop,
  output logic         res_empty,
  output sft_pkg::res_t res
);
  import sft_pkg::*;

  logic              ram_we, ram_re;
  logic [WORD_W-1:0] ram_rdata;

  logic              s2_valid, s2_read, s2_last;
  status_t           s2_status;

  res_t              rq [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              rq_pop;
  logic              has_room;
  res_t              rq_in;

  // Result-making ops go only when the result queue can take everything in flight.
  assign has_room = (count + QCNT_W'(s2_valid)) < QCNT_W'(QUEUE_DEPTH);

  always_comb begin
    op_pop = 1'b0;
    ram_we = 1'b0;
    ram_re = 1'b0;
    if (op_valid) begin
      case (op.kind)
        OP_WRITE: begin
          op_pop = 1'b1;
          ram_we = 1'b1;
        end
        OP_READ: begin
          op_pop = has_room;
          ram_re = has_room;
        end
        OP_ERROR: op_pop = has_room;
        default:  op_pop = 1'b1;
      endcase
    end
  end

  sft_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (op.addr),
    .wdata (op.data),
    .re    (ram_re),
    .raddr (op.addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    s2_read   <= ram_re;
    s2_last   <= op.last;
    s2_status <= op.status;
  end

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else     s2_valid <= op_pop && (op.kind != OP_WRITE);
  end

  assign rq_in.value  = s2_read ? ram_rdata : '0;
  assign rq_in.last   = s2_read && s2_last;
  assign rq_in.status = s2_status;

  assign res_empty = count == '0;
  assign res       = rq[rd_ptr];
  assign rq_pop    = res_pop && !res_empty;

  always_ff @(posedge clk) begin
    if (s2_valid) rq[wr_ptr] <= rq_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (s2_valid) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (rq_pop)   rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + QCNT_W'(s2_valid) - QCNT_W'(rq_pop);
    end
  end

endmodule

@@ tb/sample_frame_transposer_unit_test.sv @@
// Self-checking testbench for the sample frame transposer: load, fetch, conversion and error paths.
`timescale 1ns / 100ps

module sample_frame_transposer_unit_test;
  import sft_pkg::*;

  // Cycles without any accepted transaction before the run is declared hung.
  localparam int HANG_LIMIT = 2000;
  // Quiet cycles after the last result; covers the pipe plus queue slack.
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_ITEMS = 100;
  localparam int SHOW_LIMIT = 10;

  // Scoreboard: keeps its own copy of the frame store and registers, predicts the
  // result of every accepted transaction and checks popped results in order.
  class transposer_scoreboard;
    logic [WORD_W-1:0] words [STORE_DEPTH];
    int unsigned fill_count;
    int unsigned next_col;
    int unsigned next_row;
    bit          frame_full;
    bit [DIM_W-1:0] width_reg;
    bit [DIM_W-1:0] height_reg;
    bit narrow;
    bit stretch;
    bit swap;
    res_t pending_results [$];
    int errors;
    int loads, fetches, frames, early, dropped, checked;

    function new();
      foreach (words[k]) words[k] = '0;
      fill_count = 0; next_col = 0; next_row = 0; frame_full = 0;
      width_reg = 7'd64; height_reg = 7'd64;
      narrow = 1; stretch = 0; swap = 0;
      errors = 0; loads = 0; fetches = 0; frames = 0; early = 0; dropped = 0; checked = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_COLS:         width_reg = data;
        REG_ROWS:         height_reg = data;
        REG_NARROW_INPUT: narrow = data[0];
        REG_RESCALE:      stretch = data[0];
        REG_SWAP_BYTES:   swap = data[0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp_dim(bit [DIM_W-1:0] v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return 32'(v);
    endfunction

    function logic [WORD_W-1:0] convert_word(logic [WORD_W-1:0] s);
      logic [WORD_W-1:0] w;
      w = s;
      if (narrow) begin
        // v*257 is just the byte repeated
        w = stretch ? {s[7:0], s[7:0]} : {8'h00, s[7:0]};
      end
      if (swap) w = {w[7:0], w[15:8]};
      return w;
    endfunction

    // Advances the predicted state by one accepted transaction.
    function void transpose_step(cmd_t cmd, logic [WORD_W-1:0] smp);
      int unsigned ec;
      int unsigned er;
      int unsigned addr;
      res_t r;
      ec = clamp_dim(width_reg, MAX_COLS);
      er = clamp_dim(height_reg, MAX_ROWS);
      r.value = '0;
      r.last = 1'b0;
      r.status = ST_OK;
      if (cmd == CMD_LOAD) begin
        loads++;
        if (frame_full) begin
          r.status = ST_DROPPED;
          pending_results.push_back(r);
        end else begin
          if (fill_count < STORE_DEPTH) begin
            words[fill_count] = convert_word(smp);
            fill_count++;
          end
          if (fill_count >= ec * er) frame_full = 1;
        end
      end else begin
        fetches++;
        if (!frame_full) begin
          r.status = ST_EARLY_FETCH;
        end else begin
          addr = next_row * ec + next_col;
          if (next_row < MAX_ROWS && next_col < MAX_COLS && addr < STORE_DEPTH)
            r.value = words[addr];
          next_row++;
          if (next_row >= er) begin
            next_row = 0;
            next_col++;
            if (next_col >= ec) begin
              r.last = 1'b1;
              fill_count = 0; next_col = 0; next_row = 0; frame_full = 0;
            end
          end
        end
        pending_results.push_back(r);
      end
    endfunction

    function void check_result(logic [WORD_W-1:0] v, logic l, logic [1:0] st);
      res_t e;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= SHOW_LIMIT)
          $display("[%0t] unexpected result: value %h last %0d status %0d", $realtime, v, l, st);
        return;
      end
      e = pending_results.pop_front();
      checked++;
      if (e.last) frames++;
      if (e.status == ST_EARLY_FETCH) early++;
      if (e.status == ST_DROPPED) dropped++;
      if (v !== e.value || l !== e.last || st !== e.status) begin
        errors++;
        if (errors <= SHOW_LIMIT)
          $display("[%0t] mismatch: expected value %h last %0d status %0d, got %h %0d %0d",
                   $realtime, e.value, e.last, e.status, v, l, st);
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  typedef enum {RX_STREAM, RX_RANDOM, RX_SPARSE, RX_HOLD} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic command = CMD_LOAD;
  logic [WORD_W-1:0] sample = '0;
  logic empty;
  logic pop = 1'b0;
  logic [WORD_W-1:0] value;
  logic last;
  logic [1:0] status;

  transposer_scoreboard sb = new();

  // sender burst state
  int burst_left = 0;
  int items_sent = 0;
  int settings_run = 0;
  // receiver stall pattern state
  rx_mode_t rx_mode = RX_STREAM;
  int rx_left = 0;
  int rx_tick = 0;
  int quiet_cycles = 0;

  sample_frame_transposer_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .command   (command),
    .sample    (sample),
    .empty     (empty),
    .pop       (pop),
    .value     (value),
    .last      (last),
    .status    (status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: checks each popped transaction and stalls on a mode pattern of its own:
  // streaming, coin-flip, one-in-four, or a hard hold long enough to back the queues up.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) sb.check_result(value, last, status);
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = (rx_mode == RX_HOLD) ? $urandom_range(5, 40) : $urandom_range(20, 150);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
        RX_STREAM: pop <= 1'b1;
        RX_RANDOM: pop <= 1'($urandom_range(0, 1));
        RX_SPARSE: pop <= (rx_tick % 4 == 0);
        default:   pop <= 1'b0;
      endcase
    end
  end

  // Watchdog: any accepted transaction on either side resets the count.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("[%0t] no transaction for %0d cycles, %0d results outstanding",
                 $realtime, HANG_LIMIT, sb.pending());
        $display("sample_frame_transposer_unit_test: done, errors");
        $finish;
      end
    end
  end

  function automatic logic [WORD_W-1:0] rnd_sample();
    // bias towards the corner patterns now and then
    case ($urandom_range(0, 11))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h00FF;
      3: return 16'hFF00;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Offers one transaction and holds it until taken; then either keeps push high
  // for the next one in the burst or drops it for a random gap.
  task automatic send_item(cmd_t cmd, logic [WORD_W-1:0] smp);
    int gap;
    push <= 1'b1;
    command <= cmd;
    sample <= smp;
    do @(posedge clk); while (full);
    sb.transpose_step(cmd, smp);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(0, 15);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every predicted result has been popped.
  task automatic wait_results();
    if (push) push <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_register(idx, data);
  endtask

  // Reprogramme all registers with the block idle. A loaded frame is read out first
  // so that a size change can never point a read at a word nobody wrote.
  task automatic write_config(logic [CFG_DATA_W-1:0] c, logic [CFG_DATA_W-1:0] r,
                              bit n, bit s, bit w);
    while (sb.frame_full) send_item(CMD_FETCH, rnd_sample());
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    put_reg(REG_COLS, c);
    put_reg(REG_ROWS, r);
    put_reg(REG_NARROW_INPUT, {6'd0, n});
    put_reg(REG_RESCALE, {6'd0, s});
    put_reg(REG_SWAP_BYTES, {6'd0, w});
    cfg_write <= 1'b0;
    settings_run++;
  endtask

  // Mostly a clean fill-then-drain of one frame; with noise, stray fetches during the
  // fill, stray loads into the full store and the odd abandoned fill; at any noise, the odd mid-read pause.
  task automatic run_frame(int noise);
    while (!sb.frame_full) begin
      if ($urandom_range(0, 99) < noise) begin
        if ($urandom_range(0, 9) == 0) return;
        send_item(CMD_FETCH, rnd_sample());
      end else begin
        send_item(CMD_LOAD, rnd_sample());
      end
    end
    while (sb.frame_full) begin
      if ($urandom_range(0, 99) < noise) send_item(CMD_LOAD, rnd_sample());
      else send_item(CMD_FETCH, rnd_sample());
      if ($urandom_range(0, 49) == 0) wait_results();
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return 7'($urandom_range(1, 8));
    if (r == 8) return 7'($urandom_range(9, 12));
    // out of range: zero saturates to 1
    return 7'd0;
  endfunction

  initial begin
    int random_start;
    int noise;
    int nframes;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: fetch straight out of reset is early.
    send_item(CMD_FETCH, 16'h1357);

    // 3 wide by 2 high, full 16-bit samples, no conversion: corner patterns,
    // a load into the full store, a complete transposed read, then an early fetch.
    write_config(7'd3, 7'd2, 1'b0, 1'b0, 1'b0);
    send_item(CMD_LOAD, 16'h0000);
    send_item(CMD_LOAD, 16'hFFFF);
    send_item(CMD_LOAD, 16'h8001);
    send_item(CMD_LOAD, 16'h00FF);
    send_item(CMD_LOAD, 16'hFF00);
    send_item(CMD_LOAD, 16'h1234);
    send_item(CMD_LOAD, 16'hBEEF);
    repeat (6) send_item(CMD_FETCH, 16'h0000);
    send_item(CMD_FETCH, 16'hFFFF);

    // Single-sample frame, narrow with stretch and swap.
    write_config(7'd1, 7'd1, 1'b1, 1'b1, 1'b1);
    send_item(CMD_LOAD, 16'h12C3);
    send_item(CMD_FETCH, 16'h0000);

    // Narrow, no stretch, swapped; the high byte of the input must be ignored.
    write_config(7'd2, 7'd1, 1'b1, 1'b0, 1'b1);
    send_item(CMD_LOAD, 16'h00FF);
    send_item(CMD_LOAD, 16'hFF80);
    send_item(CMD_FETCH, 16'h0000);
    send_item(CMD_FETCH, 16'h0000);

    // Size extremes: zero and 127 saturate to 1 and to 64.
    write_config(7'd0, 7'd127, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    run_frame(0);
    write_config(7'd127, 7'd0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    run_frame(0);

    // Random settings, a few frames each.
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      write_config(pick_dim(), pick_dim(), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      noise = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      nframes = $urandom_range(1, 4);
      repeat (nframes) run_frame(noise);
    end

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.errors += sb.pending();
      $display("%0d expected results never arrived", sb.pending());
    end
    if (sb.errors > SHOW_LIMIT)
      $display("%0d further mismatches not shown", sb.errors - SHOW_LIMIT);
    $display("covered %0d loads and %0d fetches over %0d register settings",
             sb.loads, sb.fetches, settings_run);
    $display("checked %0d results: %0d whole frames, %0d early fetches, %0d dropped loads",
             sb.checked, sb.frames, sb.early, sb.dropped);
    if (sb.errors == 0) begin
      $display("sample_frame_transposer_unit_test: done, clean");
    end else begin
      $display("sample_frame_transposer_unit_test: done, errors");
    end
    $finish;
  end

endmodule

@@ sample_frame_transposer_unit.f @@
sv/sft_pkg.sv
sv/sft_ram.sv
sv/sft_front.sv
sv/sft_op_queue.sv
sv/sft_back.sv
sv/sample_frame_transposer_unit.sv
tb/sample_frame_transposer_unit_test.sv
